### sv/lppa_pkg.sv
`default_nettype none
package lppa_pkg;

  // field widths
  localparam int unsigned LEN_W   = 15;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned BATCH_W = 17;
  localparam int unsigned TICK_W  = 16;

  // longest packet accepted, in bytes
  localparam logic [REG_W-1:0] MAX_PACKET = 16'd16384;

  // register reset values
  localparam logic [REG_W-1:0] TARGET_RESET = 16'd3000;
  localparam logic [REG_W-1:0] WINDOW_RESET = 16'd10000;

  // register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 1'b1;

  // input request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  // result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // command queue depth
  localparam int unsigned QDEPTH = 4;

  // slots of one command, emitted from the top bit down
  localparam int unsigned SLOT_N    = 4;
  localparam int unsigned SLOT_END  = 3;
  localparam int unsigned SLOT_HI   = 2;
  localparam int unsigned SLOT_LO   = 1;
  localparam int unsigned SLOT_DATA = 0;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic [LEN_W-1:0]  packet_len;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
  } out_word_t;

  typedef struct packed {
    logic [SLOT_N-1:0] mask;
    logic [BYTE_W-1:0] hdr_hi;
    logic [BYTE_W-1:0] hdr_lo;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // queue handshake toward the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage
`default_nettype wire

### sv/lppa_front.sv
`default_nettype none
module lppa_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  input  lppa_pkg::in_word_t                in_word,
  input  wire                               q_full,
  output logic                              push,
  output lppa_pkg::cmd_t                    push_cmd,
  input  wire                               cfg_we,
  input  wire [lppa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [lppa_pkg::REG_W-1:0]         cfg_wdata
);

  logic [lppa_pkg::REG_W-1:0]   target_r, target_nxt;
  logic [lppa_pkg::REG_W-1:0]   window_r, window_nxt;
  logic [lppa_pkg::BATCH_W-1:0] batch_r, batch_nxt;
  logic [lppa_pkg::TICK_W-1:0]  elapsed_r, elapsed_nxt;
  logic [lppa_pkg::LEN_W-1:0]   left_r, left_nxt;

  logic                          accept;
  logic [lppa_pkg::TICK_W-1:0]  el_tick;
  logic [lppa_pkg::TICK_W-1:0]  el_chk;
  logic                          flush;
  logic                          len_ok;
  logic [lppa_pkg::BATCH_W-1:0] batch_chk;
  logic [lppa_pkg::BATCH_W:0]   sum;
  logic [lppa_pkg::SLOT_N-1:0]  mask;

  assign accept = in_valid && !q_full;

  // saturating tick count
  assign el_tick = (elapsed_r != {lppa_pkg::TICK_W{1'b1}}) ?
                   elapsed_r + 1'b1 : elapsed_r;

  // flush check sees the tick already counted
  assign el_chk = (in_word.req_type == lppa_pkg::REQ_TICK) ? el_tick : elapsed_r;
  assign flush  = (el_chk >= window_r) || (batch_r >= {1'b0, target_r});

  assign len_ok = (in_word.packet_len != '0) &&
                  ({1'b0, in_word.packet_len} <= lppa_pkg::MAX_PACKET);

  // fill after the flush check, then with the new packet and its header
  assign batch_chk = flush ? '0 : batch_r;
  assign sum = {1'b0, batch_chk} + {3'b000, in_word.packet_len} +
               {{(lppa_pkg::BATCH_W-1){1'b0}}, 2'd2};

  // apply config writes, classify the word and update batch state
  always_comb begin
    target_nxt  = target_r;
    window_nxt  = window_r;
    batch_nxt   = batch_r;
    elapsed_nxt = elapsed_r;
    left_nxt    = left_r;
    mask        = '0;
    if (cfg_we) begin
      unique case (cfg_index)
        lppa_pkg::CFG_IDX_TARGET: target_nxt = cfg_wdata;
        lppa_pkg::CFG_IDX_WINDOW: window_nxt = cfg_wdata;
        default: ;
      endcase
    end
    if (accept) begin
      if (in_word.req_type == lppa_pkg::REQ_TICK) begin
        elapsed_nxt = el_tick;
        if (left_r == '0 && flush) begin
          elapsed_nxt = '0;
          batch_nxt   = '0;
          mask[lppa_pkg::SLOT_END] = (batch_r != '0);
        end
      end else if (left_r != '0) begin
        mask[lppa_pkg::SLOT_DATA] = 1'b1;
        left_nxt = left_r - 1'b1;
      end else if (in_word.first_byte && len_ok) begin
        if (flush) begin
          elapsed_nxt = '0;
          mask[lppa_pkg::SLOT_END] = (batch_r != '0);
        end
        // packet would overflow the batch
        if (sum > {2'b00, target_r}) begin
          elapsed_nxt = '0;
          if (batch_chk != '0) begin
            mask[lppa_pkg::SLOT_END] = 1'b1;
          end
          batch_nxt = sum[lppa_pkg::BATCH_W-1:0] - batch_chk;
        end else begin
          batch_nxt = sum[lppa_pkg::BATCH_W-1:0];
        end
        mask[lppa_pkg::SLOT_HI]   = 1'b1;
        mask[lppa_pkg::SLOT_LO]   = 1'b1;
        mask[lppa_pkg::SLOT_DATA] = 1'b1;
        left_nxt = in_word.packet_len - 1'b1;
      end
    end
  end

  assign push            = accept && (mask != '0);
  assign push_cmd.mask   = mask;
  assign push_cmd.hdr_hi = {1'b0, in_word.packet_len[lppa_pkg::LEN_W-1:lppa_pkg::BYTE_W]};
  assign push_cmd.hdr_lo = in_word.packet_len[lppa_pkg::BYTE_W-1:0];
  assign push_cmd.data   = in_word.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= lppa_pkg::TARGET_RESET;
      window_r  <= lppa_pkg::WINDOW_RESET;
      batch_r   <= '0;
      elapsed_r <= '0;
      left_r    <= '0;
    end else begin
      target_r  <= target_nxt;
      window_r  <= window_nxt;
      batch_r   <= batch_nxt;
      elapsed_r <= elapsed_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/lppa_queue.sv
`default_nettype none
module lppa_queue #(
  parameter int unsigned DEPTH = lppa_pkg::QDEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  lppa_pkg::cmd_t     push_cmd,
  output logic               full,
  output lppa_pkg::q_head_t  head,
  input  wire                pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lppa_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]  wr_r, wr_nxt;
  logic [AW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = mem_r[rd_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head.valid;

  // pointer and fill count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### sv/lppa_back.sv
`default_nettype none
module lppa_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  lppa_pkg::q_head_t      head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_stall,
  output lppa_pkg::out_word_t    out_word
);

  logic [lppa_pkg::SLOT_N-1:0] cur_mask_r, cur_mask_nxt;
  lppa_pkg::cmd_t              cur_cmd_r, cur_cmd_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lppa_pkg::out_word_t         out_word_r, out_word_nxt;

  logic                        take;
  logic                        use_cur;
  logic [lppa_pkg::SLOT_N-1:0] src_mask;
  lppa_pkg::cmd_t              src_cmd;
  logic [lppa_pkg::SLOT_N-1:0] rest;

  assign take    = !out_valid_r || !out_stall;
  assign use_cur = (cur_mask_r != '0);
  assign src_mask = use_cur ? cur_mask_r : (head.valid ? head.cmd.mask : '0);
  assign src_cmd  = use_cur ? cur_cmd_r : head.cmd;
  assign pop      = take && !use_cur && head.valid;

  // emit the highest pending slot into the output register
  always_comb begin
    rest          = src_mask;
    cur_mask_nxt  = cur_mask_r;
    cur_cmd_nxt   = cur_cmd_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (take) begin
      out_valid_nxt         = (src_mask != '0);
      out_word_nxt.kind     = lppa_pkg::KIND_BYTE;
      out_word_nxt.out_byte = src_cmd.data;
      if (src_mask[lppa_pkg::SLOT_END]) begin
        rest[lppa_pkg::SLOT_END] = 1'b0;
        out_word_nxt.kind     = lppa_pkg::KIND_END;
        out_word_nxt.out_byte = '0;
      end else if (src_mask[lppa_pkg::SLOT_HI]) begin
        rest[lppa_pkg::SLOT_HI] = 1'b0;
        out_word_nxt.out_byte = src_cmd.hdr_hi;
      end else if (src_mask[lppa_pkg::SLOT_LO]) begin
        rest[lppa_pkg::SLOT_LO] = 1'b0;
        out_word_nxt.out_byte = src_cmd.hdr_lo;
      end else begin
        rest[lppa_pkg::SLOT_DATA] = 1'b0;
      end
      out_word_nxt.run_last = (rest == '0);
      cur_mask_nxt = rest;
      cur_cmd_nxt  = src_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_mask_r  <= cur_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_cmd_r  <= cur_cmd_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

### sv/length_prefixed_packet_aggregator.sv
// Path: a word's first result passes through the command queue and then the output
// register before it shows on out_valid; queued commands ahead of it add to that.
// Throughput: one input word per cycle while each word yields at most one result
// and out_stall is low; a packet start yields three or four results, drained one
// per cycle by the output register while out_stall is low, with a command queue of
// QDEPTH entries absorbing the burst; in_stall rises while the queue is full.
// Reset: synchronous active-low rst_n clears batch state, queue and output valid,
// and sets the target to 3000 bytes and the window to 10000 ticks.
`default_nettype none
module length_prefixed_packet_aggregator #(
  parameter int unsigned QDEPTH = lppa_pkg::QDEPTH
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  lppa_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  wire                               out_stall,
  output lppa_pkg::out_word_t               out_word,
  input  wire                               cfg_we,
  input  wire [lppa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [lppa_pkg::REG_W-1:0]         cfg_wdata
);

  logic              q_full;
  logic              push;
  lppa_pkg::cmd_t    push_cmd;
  lppa_pkg::q_head_t head;
  logic              pop;

  assign in_stall = q_full;

  // classify words and keep batch state
  lppa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // commands between front and back
  lppa_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .head     (head),
    .pop      (pop)
  );

  // expand commands into output words
  lppa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

### sv/lppa_checker.sv
`default_nettype none
module lppa_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input lppa_pkg::out_word_t  out_word
);

  logic last_end_r;

  // kind of the last word taken on the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_end_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      last_end_r <= (out_word.kind == lppa_pkg::KIND_END);
    end
  end

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");

  // reset empties the output register and the queue; checked as out_valid and in_stall low
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // a batch end carries a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == lppa_pkg::KIND_END |-> out_word.out_byte == '0)
    else $error("batch end with nonzero byte");

  // an empty batch is never ended, so two ends never follow each other
  a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == lppa_pkg::KIND_END |-> !last_end_r)
    else $error("two batch ends in a row");

  // input stays open while the output is idle
  a_open_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(!in_valid) && $past(!out_valid, 2)
      && $past(!in_valid, 2) |-> !in_stall || in_valid)
    else $error("input stalled while idle");

endmodule

bind length_prefixed_packet_aggregator lppa_checker u_lppa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire
